@@ hdl/dnv_pkg.sv @@
package dnv_pkg;

   localparam int MAX_NAME_LENGTH = 255;
   localparam int LABEL_LIMIT     = 62;
   localparam int LEN_W           = $clog2(MAX_NAME_LENGTH + 2);
   localparam int LAB_W           = $clog2(LABEL_LIMIT + 2);
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_BADNAME = 3'd1;
   localparam logic [2:0] ST_NUMERIC = 3'd2;
   localparam logic [2:0] ST_NONRFC  = 3'd3;
   localparam logic [2:0] ST_BADCHAR = 3'd4;

   localparam logic [2:0] FMT_DOMAIN      = 3'd0;
   localparam logic [2:0] FMT_DOMAIN_LBL  = 3'd1;
   localparam logic [2:0] FMT_HOST        = 3'd2;
   localparam logic [2:0] FMT_HOST_LBL    = 3'd3;
   localparam logic [2:0] FMT_WILDCARD    = 3'd4;
   localparam logic [2:0] FMT_SRV         = 3'd5;

   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_DOT   = 2'd1;
   localparam logic [1:0] KIND_STAR  = 2'd2;
   localparam logic [1:0] KIND_UNDER = 2'd3;

   // per code unit class; the punctuation group bits are mutually exclusive
   typedef struct packed {
      logic zero;
      logic dot;
      logic digit;
      logic badpun;
      logic ext;
      logic blank;
      logic under;
      logic star;
   } char_class_type;

   typedef struct packed {
      char_class_type cls;
      logic           last;
      logic           empty;
      logic [2:0]     fmt;
   } q_item_type;

   typedef struct packed {
      logic ext;
      logic digit;
      logic nondig;
      logic period;
      logic period2;
      logic blank;
      logic badpun;
      logic star;
      logic under;
      logic long_lbl;
   } seen_flags_type;

   function automatic logic is_bad_punct(input logic [15:0] c);
      logic r;
      r = 1'b0;
      unique case (c)
         16'h007B, 16'h007C, 16'h007D, 16'h007E, 16'h005B, 16'h005C, 16'h005D,
         16'h005E, 16'h0027, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E,
         16'h003F, 16'h0040, 16'h0021, 16'h0022, 16'h0023, 16'h0024, 16'h0025,
         16'h0060, 16'h0028, 16'h0029, 16'h002B, 16'h002F, 16'h002C: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

@@ hdl/dnv_front.sv @@
module dnv_front (
   input  logic                [15:0] req_code_unit,
   input  logic                       req_last_unit,
   input  logic                       req_empty_name,
   input  logic                [2:0]  req_name_format,
   output dnv_pkg::q_item_type        item
);
   import dnv_pkg::*;

   char_class_type cls;

   always_comb begin
      cls        = '0;
      cls.zero   = (req_code_unit == 16'h0000);
      cls.dot    = (req_code_unit == 16'h002E);
      cls.digit  = (req_code_unit >= 16'h0030) && (req_code_unit <= 16'h0039);
      priority if (is_bad_punct(req_code_unit)) begin
         cls.badpun = 1'b1;
      end else if (req_code_unit > 16'd127) begin
         cls.ext = 1'b1;
      end else if (req_code_unit == 16'h0020) begin
         cls.blank = 1'b1;
      end else if (req_code_unit == 16'h005F) begin
         cls.under = 1'b1;
      end else if (req_code_unit == 16'h002A) begin
         cls.star = 1'b1;
      end else begin
         cls.badpun = 1'b0;
      end
   end

   assign item.cls   = cls;
   assign item.last  = req_last_unit;
   assign item.empty = req_empty_name;
   assign item.fmt   = req_name_format;

endmodule

@@ hdl/dnv_queue.sv @@
module dnv_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  dnv_pkg::q_item_type push_item,
   output logic                pop_valid,
   input  logic                pop_ready,
   output dnv_pkg::q_item_type pop_item
);
   import dnv_pkg::*;

   q_item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hdl/dnv_back.sv @@
module dnv_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   output logic                item_ready,
   input  dnv_pkg::q_item_type item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_status
);
   import dnv_pkg::*;

   seen_flags_type    flags_ff, flags_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LAB_W-1:0]  lab_ff, lab_in;
   logic              prev_dot_ff, prev_dot_in;
   logic [1:0]        first_kind_ff, first_kind_in;
   logic              second_dot_ff, second_dot_in;
   logic              halted_ff, halted_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;

   logic              ends, take, fire;
   logic [LAB_W-1:0]  lab_tmp;
   logic              numeric, nonrfc, badch, wild_bad, bad_generic;
   logic [2:0]        verdict;

   assign ends       = item.empty || item.last;
   assign item_ready = !ends || !rsp_valid_ff || rsp_ready;
   assign fire       = item_valid && item_ready;
   assign take       = !item.empty && !item.cls.zero && !halted_ff;

   // character update
   always_comb begin
      flags_in      = flags_ff;
      len_in        = len_ff;
      lab_in        = lab_ff;
      prev_dot_in   = prev_dot_ff;
      first_kind_in = first_kind_ff;
      second_dot_in = second_dot_ff;
      halted_in     = halted_ff || (!item.empty && item.cls.zero);
      lab_tmp       = item.cls.dot ? '0 : lab_ff;
      if (take) begin
         if (item.cls.dot) begin
            flags_in.period = 1'b1;
            if (prev_dot_ff) begin
               flags_in.period2 = 1'b1;
            end
         end else if (item.cls.digit) begin
            flags_in.digit = 1'b1;
         end else begin
            flags_in.nondig = 1'b1;
         end
         if (lab_tmp > LAB_W'(LABEL_LIMIT)) begin
            flags_in.long_lbl = 1'b1;
         end
         if (item.cls.badpun) flags_in.badpun = 1'b1;
         if (item.cls.ext)    flags_in.ext    = 1'b1;
         if (item.cls.blank)  flags_in.blank  = 1'b1;
         if (item.cls.under)  flags_in.under  = 1'b1;
         if (item.cls.star)   flags_in.star   = 1'b1;
         if (len_ff == '0) begin
            priority if (item.cls.dot) begin
               first_kind_in = KIND_DOT;
            end else if (item.cls.star) begin
               first_kind_in = KIND_STAR;
            end else if (item.cls.under) begin
               first_kind_in = KIND_UNDER;
            end else begin
               first_kind_in = KIND_OTHER;
            end
         end else if (len_ff == LEN_W'(1)) begin
            second_dot_in = item.cls.dot;
         end
         if (len_ff <= LEN_W'(MAX_NAME_LENGTH)) begin
            len_in = len_ff + 1'b1;
         end
         lab_in      = (lab_tmp <= LAB_W'(LABEL_LIMIT)) ? lab_tmp + 1'b1 : lab_tmp;
         prev_dot_in = item.cls.dot;
      end
   end

   // end-of-name judgement on the updated state
   always_comb begin
      numeric     = !flags_in.nondig && flags_in.digit;
      nonrfc      = flags_in.ext || flags_in.under;
      badch       = flags_in.blank || flags_in.badpun || flags_in.star;
      wild_bad    = flags_in.ext || flags_in.blank || flags_in.badpun;
      bad_generic = (len_in == '0) || (len_in > LEN_W'(MAX_NAME_LENGTH)) ||
                    flags_in.long_lbl || flags_in.period2 ||
                    (first_kind_in == KIND_DOT && len_in >= LEN_W'(2));
      verdict     = ST_OK;
      if (bad_generic) begin
         verdict = ST_BADNAME;
      end else begin
         unique case (item.fmt)
            FMT_DOMAIN, FMT_HOST: begin
               priority if (numeric) verdict = ST_NUMERIC;
               else if (nonrfc)      verdict = ST_NONRFC;
               else if (badch)       verdict = ST_BADCHAR;
               else                  verdict = ST_OK;
            end
            FMT_DOMAIN_LBL: begin
               priority if (flags_in.period) verdict = ST_BADNAME;
               else if (nonrfc)               verdict = ST_NONRFC;
               else if (badch)                verdict = ST_BADCHAR;
               else                           verdict = ST_OK;
            end
            FMT_HOST_LBL: begin
               priority if (flags_in.period) verdict = ST_BADNAME;
               else if (numeric)              verdict = ST_NUMERIC;
               else if (nonrfc)               verdict = ST_NONRFC;
               else if (badch)                verdict = ST_BADCHAR;
               else                           verdict = ST_OK;
            end
            FMT_WILDCARD: begin
               priority if (numeric)                          verdict = ST_BADNAME;
               else if (first_kind_in != KIND_STAR)           verdict = ST_BADNAME;
               else if (len_in >= LEN_W'(2) && !second_dot_in) verdict = ST_BADCHAR;
               else if (wild_bad)                             verdict = ST_BADNAME;
               else                                           verdict = ST_OK;
            end
            FMT_SRV: begin
               priority if (numeric)                           verdict = ST_BADNAME;
               else if (first_kind_in != KIND_UNDER)           verdict = ST_BADNAME;
               else if (flags_in.under && len_in == LEN_W'(1)) verdict = ST_NONRFC;
               else if (wild_bad)                              verdict = ST_BADNAME;
               else                                            verdict = ST_OK;
            end
            default: verdict = ST_OK;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      if (fire && ends) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && ends)) begin
         flags_ff      <= '0;
         len_ff        <= '0;
         lab_ff        <= '0;
         prev_dot_ff   <= 1'b0;
         first_kind_ff <= KIND_OTHER;
         second_dot_ff <= 1'b0;
         halted_ff     <= 1'b0;
      end else if (fire) begin
         flags_ff      <= flags_in;
         len_ff        <= len_in;
         lab_ff        <= lab_in;
         prev_dot_ff   <= prev_dot_in;
         first_kind_ff <= first_kind_in;
         second_dot_ff <= second_dot_in;
         halted_ff     <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule

@@ hdl/dns_name_validator.sv @@
// Path: the item that ends a name is written into the character queue, then
// judged by the back end, which loads its status into the status register.
// Throughput: one code unit per cycle, set by the state update in the back end,
// while no waiting status holds a name-ending item at the head of the queue;
// the units behind it then wait in the queue. Reset (synchronous, active high)
// empties the queue, drops any pending status and clears all per-name state.
module dns_name_validator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_code_unit,
   input  logic        req_last_unit,
   input  logic        req_empty_name,
   input  logic [2:0]  req_name_format,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status
);
   import dnv_pkg::*;

   q_item_type front_item;   // classified code unit
   q_item_type back_item;    // head of the queue
   logic       back_valid;
   logic       back_ready;

   // Front: classifies each code unit (dot, digit, punctuation group, zero).
   dnv_front u_front (
      .req_code_unit   (req_code_unit),
      .req_last_unit   (req_last_unit),
      .req_empty_name  (req_empty_name),
      .req_name_format (req_name_format),
      .item            (front_item)
   );

   // Short queue decouples the input transfer from the back end, so a stalled
   // status does not block the code units ahead of the next name-ending item.
   dnv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_item  (front_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_item   (back_item)
   );

   // Back: accumulates flags, lengths and first-character info; on the ending
   // item judges the name by its format and loads the status register.
   dnv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (back_valid),
      .item_ready (back_ready),
      .item       (back_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status)
   );

endmodule

@@ tb/name_status_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the DNS name validator, predicts the status of every
// name that ends and compares it with the status that comes out.
module name_status_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [15:0] req_code_unit,
   input  logic        req_last_unit,
   input  logic        req_empty_name,
   input  logic [2:0]  req_name_format,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_status,
   output int          fail_count,
   output int          status_pending
);
   import dnv_pkg::*;

   localparam logic [15:0] CH_NUL    = 16'h0000;
   localparam logic [15:0] CH_SPACE  = 16'h0020;
   localparam logic [15:0] CH_STAR   = 16'h002A;
   localparam logic [15:0] CH_DOT    = 16'h002E;
   localparam logic [15:0] CH_ZERO   = 16'h0030;
   localparam logic [15:0] CH_NINE   = 16'h0039;
   localparam logic [15:0] CH_UNDER  = 16'h005F;
   localparam logic [15:0] CH_BTICK  = 16'h0060;
   localparam logic [15:0] ASCII_TOP = 16'h007F;

   // forbidden punctuation, backtick handled on its own
   string punct_set = "{|}~[\\]^':;<=>?@!\"#$%()+/,";

   seen_flags_type   seen;
   logic [LEN_W-1:0] name_len;
   logic [LAB_W-1:0] label_cnt;
   logic             prev_dot;
   logic [1:0]       first_kind;
   logic             second_dot;
   logic             halted;

   logic [2:0] status_due[$];
   int         mismatches;

   initial mismatches = 0;

   function automatic logic forbidden_punct(input logic [15:0] c);
      logic hit;
      hit = (c == CH_BTICK);
      for (int k = 0; k < punct_set.len(); k++)
         if (c == {8'h00, punct_set[k]}) hit = 1'b1;
      return hit;
   endfunction

   task automatic clear_name();
      seen       = '0;
      name_len   = '0;
      label_cnt  = '0;
      prev_dot   = 1'b0;
      first_kind = KIND_OTHER;
      second_dot = 1'b0;
      halted     = 1'b0;
   endtask

   task automatic absorb_code_unit(input logic [15:0] c);
      logic dot;
      dot = (c == CH_DOT);
      if (dot) begin
         label_cnt  = '0;
         seen.period = 1'b1;
         if (prev_dot) seen.period2 = 1'b1;
      end else if (c < CH_ZERO || c > CH_NINE) begin
         seen.nondig = 1'b1;
      end else begin
         seen.digit = 1'b1;
      end
      // checked after a dot clears the count: later labels get one less
      if (label_cnt > LABEL_LIMIT) seen.long_lbl = 1'b1;

      if (forbidden_punct(c))  seen.badpun = 1'b1;
      else if (c > ASCII_TOP)  seen.ext    = 1'b1;
      else if (c == CH_SPACE)  seen.blank  = 1'b1;
      else if (c == CH_UNDER)  seen.under  = 1'b1;
      else if (c == CH_STAR)   seen.star   = 1'b1;

      if (name_len == 0) begin
         first_kind = dot ? KIND_DOT : (c == CH_STAR) ? KIND_STAR :
                      (c == CH_UNDER) ? KIND_UNDER : KIND_OTHER;
      end else if (name_len == 1) begin
         second_dot = dot;
      end
      if (name_len <= MAX_NAME_LENGTH) name_len = name_len + 1'b1;
      if (label_cnt <= LABEL_LIMIT) label_cnt = label_cnt + 1'b1;
      prev_dot = dot;
   endtask

   function automatic logic [2:0] rule_status(input logic [2:0] fmt);
      logic numeric;
      logic nonrfc;
      logic badch;
      logic wild_bad;
      numeric  = !seen.nondig && seen.digit;
      nonrfc   = seen.ext || seen.under;
      badch    = seen.blank || seen.badpun || seen.star;
      wild_bad = seen.ext || seen.blank || seen.badpun;

      if (name_len == 0 || name_len > MAX_NAME_LENGTH || seen.long_lbl || seen.period2 ||
          (first_kind == KIND_DOT && name_len >= 2))
         return ST_BADNAME;

      case (fmt)
         FMT_DOMAIN, FMT_HOST: begin
            if (numeric) return ST_NUMERIC;
            if (nonrfc)  return ST_NONRFC;
            if (badch)   return ST_BADCHAR;
         end
         FMT_DOMAIN_LBL: begin
            if (seen.period) return ST_BADNAME;
            if (nonrfc)      return ST_NONRFC;
            if (badch)       return ST_BADCHAR;
         end
         FMT_HOST_LBL: begin
            if (seen.period) return ST_BADNAME;
            if (numeric)     return ST_NUMERIC;
            if (nonrfc)      return ST_NONRFC;
            if (badch)       return ST_BADCHAR;
         end
         FMT_WILDCARD: begin
            if (numeric)                    return ST_BADNAME;
            if (first_kind != KIND_STAR)    return ST_BADNAME;
            if (name_len >= 2 && !second_dot) return ST_BADCHAR;
            if (wild_bad)                   return ST_BADNAME;
         end
         FMT_SRV: begin
            if (numeric)                    return ST_BADNAME;
            if (first_kind != KIND_UNDER)   return ST_BADNAME;
            if (seen.under && name_len == 1) return ST_NONRFC;
            if (wild_bad)                   return ST_BADNAME;
         end
         default: ;
      endcase
      return ST_OK;
   endfunction

   always @(posedge clock) begin
      logic [2:0] want;
      if (reset) begin
         clear_name();
         status_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (status_due.size() == 0) begin
               $display("%0t: status mismatch, expected none, actual %0d",
                        $time, rsp_status);
               mismatches++;
            end else begin
               want = status_due.pop_front();
               if (rsp_status !== want) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want, rsp_status);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (!req_empty_name) begin
               if (req_code_unit == CH_NUL) halted = 1'b1;
               else if (!halted) absorb_code_unit(req_code_unit);
            end
            if (req_empty_name || req_last_unit) begin
               status_due.push_back(rule_status(req_name_format));
               clear_name();
            end
         end
      end
      status_pending <= status_due.size();
      fail_count     <= mismatches;
   end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the DNS name validator. Checking lives in
// name_status_checker, which sits beside the block on the same wires.
module testbench;
   import dnv_pkg::*;

   // format codes with no rule of their own
   localparam logic [2:0] FMT_NO_RULE_LO = 3'd6;
   localparam logic [2:0] FMT_NO_RULE_HI = 3'd7;

   localparam logic [15:0] CH_NUL    = 16'h0000;
   localparam logic [15:0] CH_SPACE  = 16'h0020;
   localparam logic [15:0] CH_STAR   = 16'h002A;
   localparam logic [15:0] CH_HYPHEN = 16'h002D;
   localparam logic [15:0] CH_DOT    = 16'h002E;
   localparam logic [15:0] CH_UNDER  = 16'h005F;
   localparam logic [15:0] CH_DEL    = 16'h007F;
   localparam logic [15:0] CH_MAX    = 16'hFFFF;

   localparam int PHASE_UNITS = 180;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_code_unit;
   logic        req_last_unit;
   logic        req_empty_name;
   logic [2:0]  req_name_format;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;

   int fail_count;
   int status_pending;

   int send_idle_pct = 0;   // chance per cycle that the sender holds back, in percent
   int recv_idle_pct = 0;   // same for the receiver
   int hold_request  = 0;   // cycles of forced rsp_ready low, picked up by the receiver
   int units_sent    = 0;

   logic [15:0] name_buf[$];

   dns_name_validator u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_code_unit   (req_code_unit),
      .req_last_unit   (req_last_unit),
      .req_empty_name  (req_empty_name),
      .req_name_format (req_name_format),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status)
   );

   name_status_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_code_unit   (req_code_unit),
      .req_last_unit   (req_last_unit),
      .req_empty_name  (req_empty_name),
      .req_name_format (req_name_format),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .fail_count      (fail_count),
      .status_pending  (status_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #400000;
      $display("dns_name_validator test failed");
      $finish;
   end

   // Receiver: random stalls, plus a long hold-off when one is requested.
   // The hold-off is counted here so the sender keeps pushing meanwhile.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // One transfer on the request channel. Called and returns right after a
   // falling edge; valid stays high between back-to-back transfers.
   task automatic send_unit(input logic [15:0] cu, input logic last, input logic empty,
                            input logic [2:0] fmt);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_code_unit   <= cu;
      req_last_unit   <= last;
      req_empty_name  <= empty;
      req_name_format <= fmt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      units_sent++;
   endtask

   // Sends name_buf as one name. Format only counts on the ending transfer, so
   // the others carry noise there. An empty buffer always ends with the marker.
   task automatic send_name(input bit end_marker, input logic [2:0] fmt);
      int  n;
      bit  marker;
      bit  ends_here;
      n      = name_buf.size();
      marker = end_marker || (n == 0);
      for (int i = 0; i < n; i++) begin
         ends_here = !marker && (i == n - 1);
         send_unit(name_buf[i], ends_here, 1'b0,
                   ends_here ? fmt : 3'($urandom_range(0, 7)));
      end
      if (marker) send_unit(16'($urandom), 1'($urandom_range(0, 1)), 1'b1, fmt);
      name_buf.delete();
   endtask

   // Sender stops until every status has come back.
   task automatic drain_pause();
      req_valid <= 1'b0;
      do @(negedge clock); while (status_pending != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic append_text(input string s);
      for (int i = 0; i < s.len(); i++) name_buf.push_back({8'h00, s[i]});
   endtask

   function automatic logic [15:0] host_char();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 16'h0061 + 16'($urandom_range(0, 25));
         4, 5:       return 16'h0041 + 16'($urandom_range(0, 25));
         6, 7:       return 16'h0030 + 16'($urandom_range(0, 9));
         8:          return CH_HYPHEN;
         default:    return 16'h0061 + 16'($urandom_range(0, 25));
      endcase
   endfunction

   function automatic logic [15:0] noise_char();
      case ($urandom_range(0, 9))
         0:       return 16'($urandom);
         1:       return 16'($urandom_range(32, 126));   // any printable ASCII
         2:       return CH_SPACE;
         3:       return CH_UNDER;
         4:       return CH_STAR;
         5:       return CH_DOT;
         6:       return CH_NUL;
         7:       return 16'($urandom_range(128, 65535));
         8:       return $urandom_range(0, 1) ? CH_DEL : CH_DEL + 16'd1;
         default: return host_char();
      endcase
   endfunction

   task automatic append_label(input int len, input bit digits_only);
      for (int i = 0; i < len; i++)
         name_buf.push_back(digits_only ? 16'h0030 + 16'($urandom_range(0, 9)) : host_char());
   endtask

   // Letters with a dot every 41st unit: labels stay short, only the length counts.
   task automatic append_long(input int len);
      while (name_buf.size() < len) begin
         if (name_buf.size() % 41 == 40) name_buf.push_back(CH_DOT);
         else name_buf.push_back(16'h0061 + 16'($urandom_range(0, 25)));
      end
   endtask

   // Mostly well-formed names with random content; the rest is noise or labels at the long-label threshold.
   task automatic build_random_name(output logic [2:0] fmt, output bit marker);
      int r;
      int nlab;
      r      = $urandom_range(0, 99);
      fmt    = 3'($urandom_range(0, 7));
      marker = ($urandom_range(0, 11) == 0);
      if (r < 45) begin
         // plain dotted host name, sometimes an all-digit label
         nlab = $urandom_range(1, 4);
         for (int k = 0; k < nlab; k++) begin
            if (k > 0) name_buf.push_back(CH_DOT);
            append_label($urandom_range(1, 8), $urandom_range(0, 6) == 0);
         end
      end else if (r < 60) begin
         // wildcard or SRV shape
         if ($urandom_range(0, 1)) begin
            name_buf.push_back(CH_STAR);
            fmt = FMT_WILDCARD;
         end else begin
            name_buf.push_back(CH_UNDER);
            append_label($urandom_range(0, 4), 1'b0);
            fmt = FMT_SRV;
         end
         if ($urandom_range(0, 3) != 0) begin
            nlab = $urandom_range(1, 3);
            for (int k = 0; k < nlab; k++) begin
               name_buf.push_back(CH_DOT);
               append_label($urandom_range(1, 6), $urandom_range(0, 9) == 0);
            end
         end
         if ($urandom_range(0, 4) == 0) fmt = 3'($urandom_range(0, 7));
      end else if (r < 97) begin
         nlab = $urandom_range(1, 6);
         for (int k = 0; k < nlab; k++)
            name_buf.push_back($urandom_range(0, 1) ? noise_char() : host_char());
      end else begin
         // label length right at the long-label threshold, first or later label
         if ($urandom_range(0, 1)) begin
            append_label(2, 1'b0);
            name_buf.push_back(CH_DOT);
         end
         append_label($urandom_range(LABEL_LIMIT - 1, LABEL_LIMIT + 2), 1'b0);
      end
   endtask

   initial begin
      logic [2:0] fmt;
      bit         marker;
      int         phase_end;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_code_unit   = '0;
      req_last_unit   = 1'b0;
      req_empty_name  = 1'b0;
      req_name_format = FMT_DOMAIN;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed names ----
      send_name(1'b1, FMT_DOMAIN);               // empty name mark alone
      name_buf.push_back(CH_MAX);
      send_name(1'b0, FMT_NO_RULE_HI);           // top code unit, format with no rule
      append_text("*");     send_name(1'b0, FMT_WILDCARD);
      append_text("*.a");   send_name(1'b0, FMT_WILDCARD);
      append_text("_");     send_name(1'b0, FMT_SRV);
      append_text("_a.b");  send_name(1'b0, FMT_SRV);
      append_text("12");    send_name(1'b0, FMT_HOST);
      append_text("a.b");   send_name(1'b0, FMT_DOMAIN_LBL);
      append_text("a-9");   send_name(1'b0, FMT_HOST_LBL);
      append_text(".a");    send_name(1'b0, FMT_DOMAIN);
      append_text("a..b");  send_name(1'b0, FMT_HOST);
      append_text("a b");   send_name(1'b0, FMT_DOMAIN);
      append_text("x_y");   send_name(1'b0, FMT_DOMAIN);
      // zero code unit ends the text, the trailing bad character is ignored
      append_text("a");
      name_buf.push_back(CH_NUL);
      append_text("@");
      send_name(1'b0, FMT_HOST);
      append_text("a.");    send_name(1'b1, FMT_NO_RULE_LO);   // ended by the mark

      // ---- back pressure: receiver holds off while short names keep coming ----
      hold_request = 150;
      repeat (16) begin
         append_text("q");
         send_name(1'b0, FMT_HOST);
      end
      drain_pause();

      // ---- random names over three idling profiles ----
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0:       begin send_idle_pct = 35; recv_idle_pct = 67; end
            1:       begin send_idle_pct = 67; recv_idle_pct = 35; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase
         if (ph == 2) begin
            // name length right at the limit and one past it
            append_long(MAX_NAME_LENGTH);
            send_name(1'b0, FMT_DOMAIN);
            append_long(MAX_NAME_LENGTH + 1);
            send_name(1'b0, FMT_DOMAIN);
         end
         phase_end = units_sent + PHASE_UNITS;
         while (units_sent < phase_end) begin
            build_random_name(fmt, marker);
            send_name(marker, fmt);
         end
         drain_pause();
      end

      repeat (10) @(negedge clock);
      if (fail_count == 0 && status_pending == 0)
         $display("dns_name_validator test passed");
      else
         $display("dns_name_validator test failed");
      $finish;
   end

endmodule

@@ dns_name_validator.f @@
hdl/dnv_pkg.sv
hdl/dnv_front.sv
hdl/dnv_queue.sv
hdl/dnv_back.sv
hdl/dns_name_validator.sv
tb/name_status_checker.sv
tb/testbench.sv
